FILE: hw/rtl/mvt4_pkg.sv
// ----------------------------------------------------------------------------
// mvt4_pkg: shared types and constants for the 4x4 matrix-vector transform
// Holds the port widths, register map constants and the CSR write word.
// ----------------------------------------------------------------------------
package mvt4_pkg;

   // Default element format, signed Q16.16
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Vector length, one lane per row
   localparam int NUM_LANES = 4;

   // Port widths
   localparam int FIELD_W    = 32;
   localparam int SLOT_W     = 32;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   // One CSR write word
   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage

FILE: hw/rtl/mvt4_cell.sv
// ----------------------------------------------------------------------------
// mvt4_cell: one column cell of the transform chain
// Holds matrix column CELL_IDX, multiplies it by vector element CELL_IDX,
// floors each product to the element format and adds it to the running row
// sums handed in by the previous cell. Two stages: multiply, then accumulate.
// ----------------------------------------------------------------------------
module mvt4_cell
   import mvt4_pkg::*;
#(
   parameter int CELL_IDX   = 0,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int SUM_W      = 2 * DATA_WIDTH - FRAC_BITS + 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  csr_wr_type                             csr_wr,
   input  logic                                   valid_in,
   input  logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   vec_in,
   input  logic [NUM_LANES-1:0][SUM_W-1:0]        sum_in,
   output logic                                   valid_out,
   output logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   vec_out,
   output logic [NUM_LANES-1:0][SUM_W-1:0]        sum_out
);

   localparam int PROD_W   = 2 * DATA_WIDTH;
   localparam int REG_OFF  = CELL_IDX / 2;
   localparam int SLOT_LSB = (CELL_IDX % 2) * SLOT_W;

   logic [NUM_LANES-1:0][DATA_WIDTH-1:0] coef_ff;
   logic [NUM_LANES-1:0][DATA_WIDTH-1:0] coef_in;

   logic                                 valid_s1_ff;
   logic [NUM_LANES-1:0][DATA_WIDTH-1:0] vec_s1_ff;
   logic [NUM_LANES-1:0][SUM_W-1:0]      sum_s1_ff;
   logic [NUM_LANES-1:0][PROD_W-1:0]     prod_ff;
   logic [NUM_LANES-1:0][PROD_W-1:0]     prod_in;

   logic                                 valid_s2_ff;
   logic [NUM_LANES-1:0][DATA_WIDTH-1:0] vec_s2_ff;
   logic [NUM_LANES-1:0][SUM_W-1:0]      sum_s2_ff;
   logic [NUM_LANES-1:0][SUM_W-1:0]      sum_s2_in;

   // Pick up writes to this column's slot of each row register
   always_comb begin
      coef_in = coef_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (csr_wr.en && (csr_wr.index == CSR_IDX_W'(2 * i + REG_OFF))) begin
            coef_in[i] = csr_wr.data[SLOT_LSB +: DATA_WIDTH];
         end
      end
   end

   // Hold the column, reset to the identity column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            coef_ff[i] <= (i == CELL_IDX) ? DATA_WIDTH'(1) << FRAC_BITS : '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Full-precision signed products, one per row
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         prod_in[i] = PROD_W'($signed(coef_ff[i])) * PROD_W'($signed(vec_in[CELL_IDX]));
      end
   end

   // Floor each product and add it to the row sum
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         sum_s2_in[i] = sum_s1_ff[i] + SUM_W'($signed(prod_ff[i][PROD_W-1:FRAC_BITS]));
      end
   end

   // Advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s1_ff <= valid_in;
         valid_s2_ff <= valid_s1_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      vec_s1_ff <= vec_in;
      sum_s1_ff <= sum_in;
      prod_ff   <= prod_in;
      vec_s2_ff <= vec_s1_ff;
      sum_s2_ff <= sum_s2_in;
   end

   assign valid_out = valid_s2_ff;
   assign vec_out   = vec_s2_ff;
   assign sum_out   = sum_s2_ff;

endmodule

FILE: hw/rtl/mvt4_sat.sv
// ----------------------------------------------------------------------------
// mvt4_sat: output saturation stage
// Clamps each row sum to the signed element range and registers the word
// with its strobe, sign-extended to the port width.
// ----------------------------------------------------------------------------
module mvt4_sat
   import mvt4_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int SUM_W      = 2 * DATA_WIDTH - FRAC_BITS_DEF + 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  logic [NUM_LANES-1:0][SUM_W-1:0]   sum_in,
   output logic                              valid_out,
   output logic [NUM_LANES-1:0][FIELD_W-1:0] res_out
);

   localparam int TOP_W = SUM_W - DATA_WIDTH + 1;

   logic                              valid_ff;
   logic [NUM_LANES-1:0][FIELD_W-1:0] res_ff;
   logic [NUM_LANES-1:0][FIELD_W-1:0] res_in;

   // Clamp when the bits above the element do not all match its sign
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         logic [TOP_W-1:0]      top;
         logic [DATA_WIDTH-1:0] val;
         top = sum_in[i][SUM_W-1:DATA_WIDTH-1];
         if ((&top) || !(|top)) begin
            val = sum_in[i][DATA_WIDTH-1:0];
         end else if (sum_in[i][SUM_W-1]) begin
            val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end
         res_in[i] = FIELD_W'($signed(val));
      end
   end

   // Hold the strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the result word
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign valid_out = valid_ff;
   assign res_out   = res_ff;

endmodule

FILE: hw/rtl/matrix_vector_transform_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_top: 4x4 matrix times column vector
// A new vector word is taken on every cycle that start is high; busy never
// rises. Each word passes a chain of four column cells (two stages each:
// multiply, then floor and accumulate) and one saturation stage, whose
// register presents the result with rsp_valid, one word
// per cycle sustained. The receiver cannot stall: each result is shown for
// one cycle only. Matrix writes through the CSR port take effect on the
// next cycle and should only be made while no word is in flight.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_top
   import mvt4_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_W-1:0]    req_in_x,
   input  logic [FIELD_W-1:0]    req_in_y,
   input  logic [FIELD_W-1:0]    req_in_z,
   input  logic [FIELD_W-1:0]    req_in_w,
   output logic                  rsp_valid,
   output logic [FIELD_W-1:0]    rsp_out_x,
   output logic [FIELD_W-1:0]    rsp_out_y,
   output logic [FIELD_W-1:0]    rsp_out_z,
   output logic [FIELD_W-1:0]    rsp_out_w,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Row sum width: four floored products, never narrower than the element
   // plus one sign bit so the saturation stage always has a top slice
   localparam int SUM_W_RAW = 2 * DATA_WIDTH - FRAC_BITS + 2;
   localparam int SUM_W     = (SUM_W_RAW > DATA_WIDTH + 1) ? SUM_W_RAW : DATA_WIDTH + 1;

   csr_wr_type                           csr_wr;
   logic                                 chain_valid [NUM_LANES+1];
   logic [NUM_LANES-1:0][DATA_WIDTH-1:0] chain_vec   [NUM_LANES+1];
   logic [NUM_LANES-1:0][SUM_W-1:0]      chain_sum   [NUM_LANES+1];
   logic [NUM_LANES-1:0][FIELD_W-1:0]    res;

   // Never stall the requester
   assign busy = 1'b0;

   assign csr_wr.en    = csr_we;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   // Feed the head of the chain with the low element bits and zero sums
   assign chain_valid[0]  = start;
   assign chain_vec[0][0] = req_in_x[DATA_WIDTH-1:0];
   assign chain_vec[0][1] = req_in_y[DATA_WIDTH-1:0];
   assign chain_vec[0][2] = req_in_z[DATA_WIDTH-1:0];
   assign chain_vec[0][3] = req_in_w[DATA_WIDTH-1:0];
   assign chain_sum[0]    = '0;

   // One cell per matrix column
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_cell
      mvt4_cell #(
         .CELL_IDX   (k),
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .SUM_W      (SUM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_wr    (csr_wr),
         .valid_in  (chain_valid[k]),
         .vec_in    (chain_vec[k]),
         .sum_in    (chain_sum[k]),
         .valid_out (chain_valid[k+1]),
         .vec_out   (chain_vec[k+1]),
         .sum_out   (chain_sum[k+1])
      );
   end

   // Clamp and register the result word
   mvt4_sat #(
      .DATA_WIDTH (DATA_WIDTH),
      .SUM_W      (SUM_W)
   ) u_sat (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (chain_valid[NUM_LANES]),
      .sum_in    (chain_sum[NUM_LANES]),
      .valid_out (rsp_valid),
      .res_out   (res)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];
   assign rsp_out_w = res[3];

endmodule

FILE: bench/mvt4_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mvt4_checker: scoreboard for the 4x4 matrix-vector transform
// Tracks the matrix from the CSR writes and predicts M * v for every accepted
// request word. It checks each response word lane by lane against the oldest
// prediction, and hands the open and failed counts to the bench top.
// ----------------------------------------------------------------------------
module mvt4_checker
   import mvt4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [FIELD_W-1:0]    req_in_x,
   input  logic [FIELD_W-1:0]    req_in_y,
   input  logic [FIELD_W-1:0]    req_in_z,
   input  logic [FIELD_W-1:0]    req_in_w,
   input  logic                  rsp_valid,
   input  logic [FIELD_W-1:0]    rsp_out_x,
   input  logic [FIELD_W-1:0]    rsp_out_y,
   input  logic [FIELD_W-1:0]    rsp_out_z,
   input  logic [FIELD_W-1:0]    rsp_out_w,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    mismatch_count
);

   localparam int DW          = DATA_WIDTH_DEF;
   localparam int FB          = FRAC_BITS_DEF;
   localparam int MAX_PRINTED = 100;

   // Fixed-point 1.0 in the element format
   localparam logic [CSR_DATA_W-1:0] ONE_Q = 64'(1) << FB;

   typedef logic [NUM_LANES-1:0][FIELD_W-1:0] lane_vec_type;

   logic [CSR_DATA_W-1:0] matrix_rows [NUM_REGS];
   lane_vec_type          expected_vectors [$];

   // Read the low DW bits of a slot as two's complement
   function automatic longint as_element(input logic [SLOT_W-1:0] slot);
      longint val;
      val = longint'(slot);
      val = val <<< (64 - DW);
      return val >>> (64 - DW);
   endfunction

   // Form M * v: floor each product to FB fraction bits, sum, saturate to DW
   function automatic lane_vec_type transform_vector(input lane_vec_type vec);
      lane_vec_type      result;
      longint            acc;
      longint            sat_hi;
      longint            sat_lo;
      logic [SLOT_W-1:0] slot;
      sat_hi = (longint'(1) <<< (DW - 1)) - 1;
      sat_lo = -sat_hi - 1;
      for (int row = 0; row < NUM_LANES; row++) begin
         acc = 0;
         for (int col = 0; col < NUM_LANES; col++) begin
            slot = matrix_rows[row * 2 + col / 2][(col % 2) * SLOT_W +: SLOT_W];
            acc += (as_element(slot) * as_element(vec[col])) >>> FB;
         end
         if (acc > sat_hi) begin
            acc = sat_hi;
         end else if (acc < sat_lo) begin
            acc = sat_lo;
         end
         result[row] = acc[FIELD_W-1:0];
      end
      return result;
   endfunction

   // Print one line per failure, capped so a broken block cannot flood the log
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) begin
         $display("[%0t] %s", $time, what);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      lane_vec_type got;
      lane_vec_type want;
      if (reset) begin
         // Restore the identity matrix and drop anything in flight
         for (int r = 0; r < NUM_REGS; r++) begin
            matrix_rows[r] = '0;
         end
         matrix_rows[0] = ONE_Q;
         matrix_rows[2] = ONE_Q << SLOT_W;
         matrix_rows[5] = ONE_Q;
         matrix_rows[7] = ONE_Q << SLOT_W;
         expected_vectors.delete();
      end else begin
         // Retire the response word against the oldest prediction
         if (rsp_valid) begin
            got = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
            if (expected_vectors.size() == 0) begin
               report_mismatch($sformatf("response word %h with nothing expected", got));
            end else begin
               want = expected_vectors.pop_front();
               for (int lane = 0; lane < NUM_LANES; lane++) begin
                  if (got[lane] !== want[lane]) begin
                     report_mismatch($sformatf("out lane %0d: got %h, expected %h",
                                               lane, got[lane], want[lane]));
                  end
               end
            end
         end
         // Predict from the matrix as it stands before this edge's write
         if (start && !busy) begin
            expected_vectors.push_back(
               transform_vector({req_in_w, req_in_z, req_in_y, req_in_x}));
         end
         // Mirror the matrix; indexes past the register map are dropped
         if (csr_we && csr_index < NUM_REGS) begin
            matrix_rows[csr_index] = csr_wdata;
         end
      end
      outstanding <= expected_vectors.size();
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 4x4 matrix-vector transform
// Runs corner vectors against the identity, all-max, all-min and zero
// matrices. It then runs random matrices, each followed by a burst of random
// vectors, gapped in all but one phase. A side checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
   import mvt4_pkg::*;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int QUIET_PHASE     = 3;
   localparam int PIPE_LATENCY    = 9;
   localparam int IDLE_PCT        = 27;
   localparam int RUN_LIMIT_NS    = 100_000;

   // Boundary words: max, min, zero, -1 lsb, 1.0, -1.0, +1 lsb
   localparam logic [6:0][FIELD_W-1:0] CORNERS = {
      32'h0000_0001, 32'hffff_0000, 32'h0001_0000, 32'hffff_ffff,
      32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff
   };

   typedef logic [NUM_LANES-1:0][FIELD_W-1:0] lane_vec_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [FIELD_W-1:0]    req_in_x;
   logic [FIELD_W-1:0]    req_in_y;
   logic [FIELD_W-1:0]    req_in_z;
   logic [FIELD_W-1:0]    req_in_w;
   logic                  rsp_valid;
   logic [FIELD_W-1:0]    rsp_out_x;
   logic [FIELD_W-1:0]    rsp_out_y;
   logic [FIELD_W-1:0]    rsp_out_z;
   logic [FIELD_W-1:0]    rsp_out_w;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    outstanding;
   int                    mismatch_count;

   logic [CSR_DATA_W-1:0] next_matrix [NUM_REGS];
   logic                  idle_on;

   matrix_vector_transform_4x4_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_in_x  (req_in_x),
      .req_in_y  (req_in_y),
      .req_in_z  (req_in_z),
      .req_in_w  (req_in_w),
      .rsp_valid (rsp_valid),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z),
      .rsp_out_w (rsp_out_w),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mvt4_checker transform_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .req_in_z       (req_in_z),
      .req_in_w       (req_in_w),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop for a hung pipeline
   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Mostly modest magnitudes so sums stay in range; some full words and corners
   function automatic logic [FIELD_W-1:0] pick_word(input int unsigned span,
                                                     input int unsigned wide_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < wide_pct) begin
         return $urandom;
      end
      if (roll < wide_pct + 10) begin
         return CORNERS[$urandom_range(0, 6)];
      end
      return FIELD_W'($urandom_range(0, 2 * span)) - FIELD_W'(span);
   endfunction

   // Send one request word, idling first at random
   task automatic send_vector(input lane_vec_type vec);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_in_x <= vec[0];
      req_in_y <= vec[1];
      req_in_z <= vec[2];
      req_in_w <= vec[3];
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold until every predicted word has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write all eight matrix registers, then one index past the map
   task automatic commit_matrix();
      for (int r = 0; r < NUM_REGS; r++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(r);
         csr_wdata <= next_matrix[r];
         @(posedge clock);
      end
      csr_index <= CSR_IDX_W'($urandom_range(NUM_REGS, (1 << CSR_IDX_W) - 1));
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic fill_matrix(input logic [SLOT_W-1:0] elem);
      for (int r = 0; r < NUM_REGS; r++) begin
         next_matrix[r] = {elem, elem};
      end
   endtask

   // Boundary vectors, lanes listed w, z, y, x
   task automatic send_corner_vectors();
      send_vector({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      send_vector({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_vector({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      send_vector({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
      send_vector({32'hffff_0000, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff});
      send_vector({32'h7fff_0000, 32'hffff_8000, 32'h0000_8000, 32'h0000_0001});
   endtask

   initial begin
      start     <= 1'b0;
      req_in_x  <= '0;
      req_in_y  <= '0;
      req_in_z  <= '0;
      req_in_w  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      idle_on = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Identity matrix left by reset
      send_corner_vectors();
      settle();

      // Extreme matrices: saturate high, saturate low, full-size products, zero
      fill_matrix(32'h7fff_ffff);
      commit_matrix();
      send_corner_vectors();
      settle();
      fill_matrix(32'h8000_0000);
      commit_matrix();
      send_corner_vectors();
      settle();
      fill_matrix(32'h0000_0000);
      commit_matrix();
      send_corner_vectors();
      settle();

      // Random matrices, alternating mild and saturation-heavy; one phase back to back
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != QUIET_PHASE);
         for (int r = 0; r < NUM_REGS; r++) begin
            next_matrix[r] = {pick_word(1 << 18, (phase % 2) ? 30 : 5),
                              pick_word(1 << 18, (phase % 2) ? 30 : 5)};
         end
         commit_matrix();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_vector({pick_word(1 << 24, 15), pick_word(1 << 24, 15),
                         pick_word(1 << 24, 15), pick_word(1 << 24, 15)});
         end
         settle();
      end

      // Leave room for any stray strobe before the verdict
      repeat (PIPE_LATENCY + 3) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
